### rtl/core/grs_pkg.sv
// shared types and constants for the group reverse stream unit
// no dependencies
package grs_pkg;

	localparam int MAX_GROUP = 16;
	localparam int ADDR_W    = $clog2(MAX_GROUP);
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);
	localparam int DATA_W    = 32;
	localparam int SIZE_W    = 5;
	localparam int CMP_W     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHOW
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_rd;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic go_emit;
		logic final_beat;
	} dp_status_t;

endpackage

### rtl/core/grs_ctrl.sv
// controller state machine for the group reverse stream unit
// depends on grs_pkg
module grs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  grs_pkg::dp_status_t status,
	output grs_pkg::ctrl_cmd_t  cmd
);

	grs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.accept  = 1'b0;
		cmd.load_rd = 1'b0;
		cmd.step    = 1'b0;
		case (state_q)
			grs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.go_emit) begin
						state_d = grs_pkg::ST_READ;
					end
				end
			end
			grs_pkg::ST_READ: begin
				cmd.load_rd = 1'b1;
				state_d     = grs_pkg::ST_SHOW;
			end
			grs_pkg::ST_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.final_beat) begin
						state_d = grs_pkg::ST_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = grs_pkg::ST_READ;
					end
				end
			end
			default: begin
				state_d = grs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/grs_datapath.sv
// group buffer, counters and config register of the group reverse stream unit
// depends on grs_pkg
module grs_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  grs_pkg::ctrl_cmd_t                cmd,
	output grs_pkg::dp_status_t               status,
	input  logic                              cfg_we,
	input  logic        [grs_pkg::SIZE_W-1:0] cfg_data,
	input  logic signed [grs_pkg::DATA_W-1:0] value,
	input  logic                              end_of_list,
	output logic signed [grs_pkg::DATA_W-1:0] out_value,
	output logic                              last_of_burst,
	output logic                              list_done
);

	logic [grs_pkg::DATA_W-1:0] mem [grs_pkg::MAX_GROUP];
	logic [grs_pkg::DATA_W-1:0] rd_q;

	logic [grs_pkg::SIZE_W-1:0] size_q;
	logic [grs_pkg::ADDR_W-1:0] fill_q;
	logic [grs_pkg::ADDR_W-1:0] addr_q;
	logic [grs_pkg::ADDR_W-1:0] left_q;
	logic                       rev_q;
	logic                       eol_q;

	logic [grs_pkg::CMP_W-1:0] size_ext;
	logic [grs_pkg::CMP_W-1:0] k_eff;
	logic [grs_pkg::CMP_W-1:0] n_new;
	logic                      group_full;

	// effective group size: pass-through below two, saturate at buffer depth
	always_comb begin
		size_ext = grs_pkg::CMP_W'(size_q);
		if (size_ext < grs_pkg::CMP_W'(2)) begin
			k_eff = grs_pkg::CMP_W'(1);
		end else if (size_ext > grs_pkg::CMP_W'(grs_pkg::MAX_GROUP)) begin
			k_eff = grs_pkg::CMP_W'(grs_pkg::MAX_GROUP);
		end else begin
			k_eff = size_ext;
		end
		n_new      = grs_pkg::CMP_W'(fill_q) + grs_pkg::CMP_W'(1);
		group_full = (n_new >= k_eff);
	end

	assign status.go_emit    = group_full | end_of_list;
	assign status.final_beat = (left_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= grs_pkg::SIZE_RESET;
			fill_q <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd.accept) begin
				if (group_full | end_of_list) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + grs_pkg::ADDR_W'(1);
				end
			end
		end
	end

	// burst address and beat count
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			eol_q  <= end_of_list;
			rev_q  <= group_full;
			left_q <= fill_q;
			addr_q <= group_full ? fill_q : '0;
		end else if (cmd.step) begin
			left_q <= left_q - grs_pkg::ADDR_W'(1);
			addr_q <= rev_q ? (addr_q - grs_pkg::ADDR_W'(1)) : (addr_q + grs_pkg::ADDR_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[fill_q] <= value;
		end
		if (cmd.load_rd) begin
			rd_q <= mem[addr_q];
		end
	end

	assign out_value     = rd_q;
	assign last_of_burst = status.final_beat;
	assign list_done     = status.final_beat & eol_q;

endmodule

### rtl/core/group_reverse_stream_unit.sv
// top level of the group reverse stream unit
// depends on grs_pkg, grs_ctrl and grs_datapath
//
// takes a stream of signed 32-bit list elements and gives them back reversed in
// groups of group_size (0 or 1 means pass-through, values above the 16-entry
// buffer depth saturate to 16); a partial group at end of list comes out in
// arrival order. an input beat that neither completes a group nor ends the list
// is taken and yields nothing. a beat that does close a group of n elements is
// taken and is followed by n result beats, each first read from the buffer
// through its registered read port and then presented and held until the
// output is ready to take it, with the word kept stable. no new input is taken while
// a burst is being delivered. lowering group_size mid-group to at most one more
// than the waiting elements flushes them and the next beat reversed. the buffer
// needs no clearing after reset. group_size is written on its own valid/ready
// channel, always ready, and must only be written while the block is idle.
module group_reverse_stream_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [grs_pkg::DATA_W-1:0] value,
	input  logic                              end_of_list,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [grs_pkg::DATA_W-1:0] out_value,
	output logic                              last_of_burst,
	output logic                              list_done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic        [grs_pkg::SIZE_W-1:0] group_size
);

	grs_pkg::ctrl_cmd_t  cmd;
	grs_pkg::dp_status_t status;

	// config port never stalls
	assign cfg_ready = 1'b1;

	grs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	grs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_data      (group_size),
		.value         (value),
		.end_of_list   (end_of_list),
		.out_value     (out_value),
		.last_of_burst (last_of_burst),
		.list_done     (list_done)
	);

endmodule

### rtl/core/grs_checker.sv
// port-level checks for the group reverse stream unit
// depends on group_reverse_stream_unit ports; bound to it below
module grs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [grs_pkg::DATA_W-1:0] out_value,
	input logic                              last_of_burst,
	input logic                              list_done
);

	// input side is closed while a burst is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result beat is shown");

	// list_done only marks the closing beat of a burst
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && list_done) |-> last_of_burst)
		else $error("list_done without last_of_burst");

	// after the closing beat the block returns to taking input
	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_burst) |=> (in_ready && !out_valid))
		else $error("block did not go idle after the closing beat");

	// a burst beat that is not the last keeps input closed
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_burst) |=> !in_ready)
		else $error("input opened in the middle of a burst");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value)
			&& $stable(last_of_burst) && $stable(list_done)))
		else $error("stalled result beat changed");

endmodule

bind group_reverse_stream_unit grs_checker u_grs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_value     (out_value),
	.last_of_burst (last_of_burst),
	.list_done     (list_done)
);

### verif/group_reverse_stream_unit_tb.sv
// self-checking testbench for group_reverse_stream_unit: group reversal, partial
// tails, pass-through and size changes mid-group, under random idling on both sides
// depends on grs_pkg and the group_reverse_stream_unit rtl
module group_reverse_stream_unit_tb;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE       = 6;     // cycles after the last result before a size write
	localparam int LONG_HOLD    = 300;   // one long receiver hold-off
	localparam int STUCK_LIMIT  = 2000;  // cycles with no beat on any channel
	localparam int TARGET_ITEMS = 300;

	localparam logic signed [grs_pkg::DATA_W-1:0] VAL_MIN =
		{1'b1, {(grs_pkg::DATA_W-1){1'b0}}};
	localparam logic signed [grs_pkg::DATA_W-1:0] VAL_MAX =
		{1'b0, {(grs_pkg::DATA_W-1){1'b1}}};

	// shape of one list sent in the random part
	typedef enum int {
		LIST_CLEAN,  // end_of_list only on the last element
		LIST_NOISY,  // end_of_list at random spots
		LIST_OPEN    // no end_of_list at all, may leave a partial group behind
	} list_kind_t;

	typedef struct packed {
		logic signed [grs_pkg::DATA_W-1:0] value;
		logic                              last_of_burst;
		logic                              list_done;
	} result_t;

	// keeps its own copy of the group buffer and the size register and predicts
	// the reordered stream, then checks each result beat against it
	class reorder_board;
		result_t                           reordered_q[$];
		logic signed [grs_pkg::DATA_W-1:0] group_buf[grs_pkg::MAX_GROUP];
		int unsigned                       fill;
		logic [grs_pkg::SIZE_W-1:0]        size_reg;
		int unsigned                       errors;
		int unsigned                       n_elements;
		int unsigned                       n_results;
		int unsigned                       n_lists;
		int unsigned                       n_sizes;

		function new();
			fill       = 0;
			size_reg   = grs_pkg::SIZE_RESET;
			errors     = 0;
			n_elements = 0;
			n_results  = 0;
			n_lists    = 0;
			n_sizes    = 0;
		endfunction

		// 0 and 1 pass through, anything past the buffer depth saturates
		function int unsigned eff_size();
			if (size_reg < 2)
				return 1;
			if (size_reg > grs_pkg::MAX_GROUP)
				return grs_pkg::MAX_GROUP;
			return 32'(size_reg);
		endfunction

		function void set_size(logic [grs_pkg::SIZE_W-1:0] k);
			size_reg = k;
			n_sizes++;
		endfunction

		function int unsigned pending();
			return reordered_q.size();
		endfunction

		function void note_element(logic signed [grs_pkg::DATA_W-1:0] v, logic eol);
			int unsigned k;
			int unsigned n;
			result_t     r;
			k = eff_size();
			group_buf[fill] = v;
			fill++;
			n = fill;
			n_elements++;
			if (eol)
				n_lists++;
			if (n >= k || eol) begin
				for (int unsigned i = 0; i < n; i++) begin
					// full group comes out reversed, a short tail in arrival order
					r.value         = (n >= k) ? group_buf[n-1-i] : group_buf[i];
					r.last_of_burst = (i == n - 1);
					r.list_done     = (i == n - 1) && eol;
					reordered_q.push_back(r);
				end
				fill = 0;
			end
		endfunction

		function void check_beat(logic signed [grs_pkg::DATA_W-1:0] v, logic lob, logic ld);
			result_t e;
			n_results++;
			if (reordered_q.size() == 0) begin
				$display("%0t: result beat with nothing expected: out_value %0d", $time, v);
				errors++;
				return;
			end
			e = reordered_q.pop_front();
			if (v !== e.value) begin
				$display("%0t: out_value expected %0d actual %0d", $time, e.value, v);
				errors++;
			end
			if (lob !== e.last_of_burst) begin
				$display("%0t: last_of_burst expected %0b actual %0b",
					$time, e.last_of_burst, lob);
				errors++;
			end
			if (ld !== e.list_done) begin
				$display("%0t: list_done expected %0b actual %0b", $time, e.list_done, ld);
				errors++;
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [grs_pkg::DATA_W-1:0] in_value;
	logic                              in_eol;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [grs_pkg::DATA_W-1:0] out_value;
	logic                              out_lob;
	logic                              out_done;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [grs_pkg::SIZE_W-1:0]        cfg_size;

	reorder_board board = new();

	bit          sender_steady;   // sender puts no idle gaps between elements while set
	bit          long_hold_req;   // asks the receiver for one long hold-off
	int unsigned stuck_cycles;

	group_reverse_stream_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (in_value),
		.end_of_list  (in_eol),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.last_of_burst(out_lob),
		.list_done    (out_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.group_size   (cfg_size)
	);

	// every block input known from time zero
	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_value  = '0;
		in_eol    = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_size  = grs_pkg::SIZE_RESET;
	end

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// idle lengths: mostly none or short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// mostly random words, sometimes the extremes
	function automatic logic signed [grs_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// result side: sample accepted beats at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_beat(out_value, out_lob, out_done);
	end

	// receiver ready pattern, changed at the falling edge
	initial begin
		int unsigned stall_left;
		int unsigned steady_left;
		int unsigned gap;
		stall_left  = 0;
		steady_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				// long hold-off so the buffer fills and the input side stalls
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD - 1;
				steady_left   = 0;
				out_ready    <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (steady_left > 0) begin
				steady_left--;
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				steady_left = $urandom_range(20, 80);
				out_ready  <= 1'b1;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					stall_left = gap - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// watchdog: any beat on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results still expected",
				$time, stuck_cycles, board.pending());
			$display("== FAIL ==");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// entered and left at a falling edge; valid stays up between back-to-back
	// elements, so the caller lowers it when the stream pauses
	task automatic send_element(input logic signed [grs_pkg::DATA_W-1:0] v, input logic eol);
		int unsigned gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_value <= v;
		in_eol   <= eol;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_element(v, eol);
		@(negedge clk);
	endtask

	// pause the sender until every expected result is out, then wait SETTLE more in
	// case the block is still settling on an element that gave no result
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_size(input logic [grs_pkg::SIZE_W-1:0] k);
		drain();
		cfg_valid <= 1'b1;
		cfg_size  <= k;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_size(k);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_list(input int unsigned len, input list_kind_t kind);
		logic eol;
		for (int unsigned i = 1; i <= len; i++) begin
			case (kind)
				LIST_CLEAN: eol = (i == len);
				LIST_NOISY: eol = ($urandom_range(0, 4) == 0);
				default:    eol = 1'b0;
			endcase
			send_element(pick_value(), eol);
		end
	endtask

	// one random size setting with a few lists, first ones forced
	task automatic random_phase(input int idx);
		logic [grs_pkg::SIZE_W-1:0] k;
		int unsigned                eff;
		int unsigned                len;
		list_kind_t                 kind;
		if (idx == 0)
			k = grs_pkg::SIZE_W'(grs_pkg::MAX_GROUP);
		else if (idx == 1)
			k = 5'd20;       // past the buffer depth, should act as 16
		else if ($urandom_range(0, 1) == 0)
			k = grs_pkg::SIZE_W'($urandom_range(2, grs_pkg::MAX_GROUP));
		else
			k = grs_pkg::SIZE_W'($urandom_range(0, 31));
		write_size(k);
		eff           = board.eff_size();
		sender_steady = (idx == 0) || ($urandom_range(0, 3) == 0);
		if (idx == 0)
			long_hold_req = 1'b1;
		repeat ((idx == 0) ? 3 : $urandom_range(1, 3)) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(17, 40);
			else
				len = $urandom_range(1, 2 * eff + 1);
			kind = ($urandom_range(0, 5) == 0) ? LIST_NOISY : LIST_CLEAN;
			if (idx <= 1)
				len = (idx == 0) ? grs_pkg::MAX_GROUP : 2 * grs_pkg::MAX_GROUP;
			send_list(len, kind);
		end
		// sometimes leave a partial group behind for the next size write
		if ($urandom_range(0, 2) == 0)
			send_list($urandom_range(1, eff), LIST_OPEN);
	endtask

	initial begin
		int phase;
		stuck_cycles  = 0;
		sender_steady = 1'b0;
		long_hold_req = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: size 2 from reset, extremes, full group ending a list
		send_element(VAL_MIN, 1'b0);
		send_element(VAL_MAX, 1'b0);
		send_element('0, 1'b1);          // one-element tail in arrival order
		send_element('1, 1'b0);
		send_element(32'sd1, 1'b1);      // list ends exactly on a full group
		// size 0 is pass-through
		write_size(5'd0);
		send_element(32'sd5, 1'b0);
		send_element(-32'sd5, 1'b1);
		// size 4, three elements left waiting, then size lowered to 1
		write_size(5'd4);
		send_element(32'sd11, 1'b0);
		send_element(32'sd12, 1'b0);
		send_element(32'sd13, 1'b0);
		write_size(5'd1);
		send_element(32'sd14, 1'b0);     // flushes 14, 13, 12, 11
		// top of the register range saturates, short list in arrival order
		write_size(5'd31);
		send_element(32'sd21, 1'b0);
		send_element(32'sd22, 1'b0);
		send_element(32'sd23, 1'b1);
		send_element(VAL_MAX, 1'b0);
		send_element(VAL_MIN, 1'b0);
		// lowering to 2 with two waiting flushes all three reversed
		write_size(5'd2);
		send_element(32'sd31, 1'b0);
		write_size(5'd16);
		send_element(32'sd41, 1'b1);

		// random part: well-formed lists mostly, some noisy or left open
		phase = 0;
		while (board.n_elements < TARGET_ITEMS) begin
			random_phase(phase);
			phase++;
		end
		drain();
		repeat (20) @(negedge clk);

		if (board.pending() != 0) begin
			$display("%0t: %0d expected results never came", $time, board.pending());
			board.errors += board.pending();
		end
		$display("run covered %0d elements in %0d ended lists and %0d result beats,",
			board.n_elements, board.n_lists, board.n_results);
		$display("over %0d group size writes including 0, 1, 16 and sizes past the depth",
			board.n_sizes);
		if (board.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", board.errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/grs_pkg.sv
rtl/core/grs_ctrl.sv
rtl/core/grs_datapath.sv
rtl/core/group_reverse_stream_unit.sv
rtl/core/grs_checker.sv
verif/group_reverse_stream_unit_tb.sv
